// ===== rtl/uitf_pkg.sv =====
// Package with the shared constants and codes of the UART receive idle-timeout framer.
`default_nettype none
package uitf_pkg;

  // Default number of bytes that one frame can hold.
  localparam int unsigned BufferDepth = 64;

  // Width of the timeout register and its value after reset.
  localparam int unsigned TimeoutWidth = 16;
  localparam logic [TimeoutWidth-1:0] TimeoutReset = 16'd1000;

  // The idle count is 17 bits wide and saturates at its maximum.
  localparam int unsigned IdleWidth = 17;
  localparam logic [IdleWidth-1:0] IdleMax = 17'h1FFFF;

  // Payload widths of the input and result fields.
  localparam int unsigned OpWidth     = 2;
  localparam int unsigned ByteWidth   = 8;
  localparam int unsigned LengthWidth = 7;

  // Operation codes carried by the input beat.
  typedef enum logic [OpWidth-1:0] {
    OpByte = 2'd0,
    OpTick = 2'd1,
    OpTake = 2'd2
  } op_e;

endpackage
`default_nettype wire

// ===== rtl/uitf_ram.sv =====
// Generic single-write, single-read RAM with a registered, enabled read port.
`default_nettype none
module uitf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/uart_rx_idle_timeout_framer.sv =====
// Top level of the UART receive framer that closes frames on a full buffer or an idle timeout.
`default_nettype none
// Each input beat is a received byte, a time tick or a take request. Bytes and ticks are taken
// without stalling the input, also while a result beat waits on the output. A take request
// holds the input stalled while it runs: it emits the saved frame at one byte per cycle from
// the RAM read port while the output is not stalled (one beat carrying no_frame if nothing is
// saved), and the input stays stalled until the last beat of the take has been issued. The
// receive and save buffers are two banks of one RAM of 2 * 2**clog2(BUFFER_DEPTH) bytes;
// moving a closed frame to the save side swaps the banks on the tick, so no copy is made and
// no clearing pass follows reset.
module uart_rx_idle_timeout_framer #(
  parameter int unsigned BUFFER_DEPTH = uitf_pkg::BufferDepth
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // Input channel.
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic [uitf_pkg::OpWidth-1:0]         operation_i,
  input  wire logic [uitf_pkg::ByteWidth-1:0]       byte_value_i,
  // Result channel.
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic      [uitf_pkg::ByteWidth-1:0]       frame_byte_o,
  output logic      [uitf_pkg::LengthWidth-1:0]     frame_length_o,
  output logic                                      last_of_frame_o,
  output logic                                      no_frame_o,
  // Configuration channel for the timeout register.
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [uitf_pkg::TimeoutWidth-1:0]    cfg_data_i
);

  localparam int unsigned AddrWidth  = $clog2(BUFFER_DEPTH);
  localparam int unsigned CountWidth = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned RamDepth   = 2 * (2 ** AddrWidth);
  localparam logic [CountWidth-1:0] LastIndex = CountWidth'(BUFFER_DEPTH - 1);

  // Control and counter registers.
  logic [uitf_pkg::TimeoutWidth-1:0] timeout_q, timeout_d;
  logic [CountWidth-1:0]             rx_count_q, rx_count_d;
  logic [CountWidth-1:0]             save_count_q, save_count_d;
  logic [CountWidth-1:0]             take_idx_q, take_idx_d;
  logic [uitf_pkg::IdleWidth-1:0]    idle_q, idle_d;
  logic                              receiving_q, receiving_d;
  logic                              frame_done_q, frame_done_d;
  logic                              rx_bank_q, rx_bank_d;
  logic                              busy_q, busy_d;
  logic                              out_valid_q, out_valid_d;

  // Result payload registers beside the RAM read data.
  logic [uitf_pkg::LengthWidth-1:0]  length_q, length_d;
  logic                              last_q, last_d;
  logic                              no_frame_q, no_frame_d;

  // RAM ports.
  logic                              ram_we;
  logic [AddrWidth:0]                ram_waddr;
  logic                              ram_re;
  logic [AddrWidth:0]                ram_raddr;
  logic [uitf_pkg::ByteWidth-1:0]    ram_rdata;

  logic                              in_accept;
  logic                              out_free;
  logic [uitf_pkg::IdleWidth-1:0]    idle_next;
  logic [CountWidth+uitf_pkg::LengthWidth-1:0] save_count_ext;
  uitf_pkg::op_e                     op;

  assign op          = uitf_pkg::op_e'(operation_i);
  assign in_stall_o  = busy_q;
  assign in_accept   = in_valid_i & ~busy_q;
  assign out_free    = ~out_valid_q | ~out_stall_i;
  assign cfg_ready_o = 1'b1;

  // The frame length is the save count masked to the width of the field.
  assign save_count_ext = {{uitf_pkg::LengthWidth{1'b0}}, save_count_q};

  // Idle count after this tick, saturating at its maximum.
  always_comb begin
    idle_next = idle_q;
    if (receiving_q && (idle_q != uitf_pkg::IdleMax)) begin
      idle_next = idle_q + 1'b1;
    end
  end

  // Main control: config, byte storage, tick service, take sequencing and the output register.
  always_comb begin
    timeout_d    = timeout_q;
    rx_count_d   = rx_count_q;
    save_count_d = save_count_q;
    take_idx_d   = take_idx_q;
    idle_d       = idle_q;
    receiving_d  = receiving_q;
    frame_done_d = frame_done_q;
    rx_bank_d    = rx_bank_q;
    busy_d       = busy_q;
    out_valid_d  = out_valid_q;
    length_d     = length_q;
    last_d       = last_q;
    no_frame_d   = no_frame_q;
    ram_we       = 1'b0;
    ram_waddr    = {rx_bank_q, rx_count_q[AddrWidth-1:0]};
    ram_re       = 1'b0;
    ram_raddr    = {~rx_bank_q, take_idx_q[AddrWidth-1:0]};

    if (cfg_valid_i) begin
      timeout_d = cfg_data_i;
    end

    // A waiting result beat leaves when the receiver takes it.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (in_accept) begin
      case (op)
        uitf_pkg::OpByte: begin
          if (!frame_done_q) begin
            receiving_d = 1'b1;
            idle_d      = '0;
            ram_we      = 1'b1;
            rx_count_d  = rx_count_q + 1'b1;
            if (rx_count_q == LastIndex) begin
              frame_done_d = 1'b1;
            end
          end
        end
        uitf_pkg::OpTick: begin
          idle_d = idle_next;
          if (frame_done_q ||
              (receiving_q && (idle_next > {1'b0, timeout_q}))) begin
            frame_done_d = 1'b1;
            if (save_count_q == '0) begin
              // Swap banks: the closed frame becomes the saved one.
              rx_bank_d    = ~rx_bank_q;
              save_count_d = rx_count_q;
              rx_count_d   = '0;
              receiving_d  = 1'b0;
              frame_done_d = 1'b0;
              idle_d       = '0;
            end
          end
        end
        uitf_pkg::OpTake: begin
          busy_d     = 1'b1;
          take_idx_d = '0;
        end
        default: begin
        end
      endcase
    end

    // Take sequencer: one result beat per cycle while the output register is free.
    if (busy_q && out_free) begin
      out_valid_d = 1'b1;
      if (save_count_q == '0) begin
        length_d   = '0;
        last_d     = 1'b0;
        no_frame_d = 1'b1;
        busy_d     = 1'b0;
      end else begin
        ram_re     = 1'b1;
        length_d   = save_count_ext[uitf_pkg::LengthWidth-1:0];
        no_frame_d = 1'b0;
        last_d     = (take_idx_q == save_count_q - 1'b1);
        take_idx_d = take_idx_q + 1'b1;
        if (take_idx_q == save_count_q - 1'b1) begin
          busy_d       = 1'b0;
          save_count_d = '0;
        end
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q    <= uitf_pkg::TimeoutReset;
      rx_count_q   <= '0;
      save_count_q <= '0;
      take_idx_q   <= '0;
      idle_q       <= '0;
      receiving_q  <= 1'b0;
      frame_done_q <= 1'b0;
      rx_bank_q    <= 1'b0;
      busy_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      timeout_q    <= timeout_d;
      rx_count_q   <= rx_count_d;
      save_count_q <= save_count_d;
      take_idx_q   <= take_idx_d;
      idle_q       <= idle_d;
      receiving_q  <= receiving_d;
      frame_done_q <= frame_done_d;
      rx_bank_q    <= rx_bank_d;
      busy_q       <= busy_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk_i) begin
    length_q   <= length_d;
    last_q     <= last_d;
    no_frame_q <= no_frame_d;
  end

  // Both frame buffers live in the two banks of one RAM.
  uitf_ram #(
    .Width (uitf_pkg::ByteWidth),
    .Depth (RamDepth)
  ) u_buf_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (byte_value_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Result outputs; an empty take shows a zero byte.
  assign out_valid_o     = out_valid_q;
  assign frame_byte_o    = no_frame_q ? '0 : ram_rdata;
  assign frame_length_o  = length_q;
  assign last_of_frame_o = last_q;
  assign no_frame_o      = no_frame_q;

endmodule
`default_nettype wire

// ===== tb/sv/uart_rx_idle_timeout_framer_test.sv =====
// Testbench for the UART receive idle-timeout framer: byte, tick and take beats checked by a model.
`timescale 1ns / 100ps

module uart_rx_idle_timeout_framer_test;

  // Operation code that the block ignores.
  localparam logic [uitf_pkg::OpWidth-1:0] OpUnused = 2'd3;

  localparam int unsigned CycleLimit  = 400_000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned ShortGap    = 20;

  // One result beat as the block should present it.
  typedef struct packed {
    logic [uitf_pkg::ByteWidth-1:0]   data;
    logic [uitf_pkg::LengthWidth-1:0] length;
    logic                             last;
    logic                             empty;
  } frame_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [uitf_pkg::OpWidth-1:0] operation = '0;
  logic [uitf_pkg::ByteWidth-1:0] byte_value = '0;
  logic out_stall = 1'b0;
  logic cfg_valid = 1'b0;
  logic [uitf_pkg::TimeoutWidth-1:0] cfg_data = '0;
  wire in_stall;
  wire out_valid;
  wire [uitf_pkg::ByteWidth-1:0] frame_byte;
  wire [uitf_pkg::LengthWidth-1:0] frame_length;
  wire last_of_frame;
  wire no_frame;
  wire cfg_ready;

  // Framer state as the testbench tracks it.
  logic [uitf_pkg::ByteWidth-1:0] rx_mem [uitf_pkg::BufferDepth];
  logic [uitf_pkg::ByteWidth-1:0] save_mem [uitf_pkg::BufferDepth];
  int unsigned rx_fill = 0;
  int unsigned save_fill = 0;
  bit rx_active = 1'b0;
  bit frame_closed = 1'b0;
  logic [uitf_pkg::IdleWidth-1:0] idle_count = '0;
  logic [uitf_pkg::TimeoutWidth-1:0] timeout_reg = uitf_pkg::TimeoutReset;
  frame_beat_t expected_beats[$];

  // Traffic shaping and bookkeeping.
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  bit hold_pending = 1'b0;
  int unsigned cycles = 0;
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned beats_checked = 0;
  int unsigned frames_taken = 0;
  int unsigned empty_takes = 0;
  int unsigned bytes_dropped = 0;
  int unsigned full_closes = 0;
  int unsigned timeout_writes = 0;

  uart_rx_idle_timeout_framer dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .operation_i    (operation),
    .byte_value_i   (byte_value),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .frame_byte_o   (frame_byte),
    .frame_length_o (frame_length),
    .last_of_frame_o(last_of_frame),
    .no_frame_o     (no_frame),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data)
  );

  // Free-running 10 ns clock.
  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop if the run hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Run stopped after %0d cycles with %0d beats outstanding.", cycles,
               expected_beats.size());
      $display("FAILURE");
      $finish;
    end
  end

  // Update the tracked state for one accepted beat and queue the beats it should produce.
  function automatic void apply_beat(input logic [uitf_pkg::OpWidth-1:0] op,
                                     input logic [uitf_pkg::ByteWidth-1:0] value);
    frame_beat_t beat;
    case (op)
      uitf_pkg::OpByte: begin
        if (frame_closed) begin
          bytes_dropped++;
        end else begin
          rx_active = 1'b1;
          idle_count = '0;
          if (rx_fill < uitf_pkg::BufferDepth) begin
            rx_mem[rx_fill] = value;
            rx_fill++;
          end
          if (rx_fill >= uitf_pkg::BufferDepth) begin
            frame_closed = 1'b1;
            full_closes++;
          end
        end
      end
      uitf_pkg::OpTick: begin
        if (rx_active && idle_count != uitf_pkg::IdleMax) idle_count++;
        if (frame_closed || (rx_active && idle_count > timeout_reg)) begin
          frame_closed = 1'b1;
          // The closed frame only moves once the save side has been taken.
          if (save_fill == 0) begin
            for (int i = 0; i < rx_fill; i++) save_mem[i] = rx_mem[i];
            save_fill = rx_fill;
            rx_fill = 0;
            rx_active = 1'b0;
            frame_closed = 1'b0;
            idle_count = '0;
          end
        end
      end
      uitf_pkg::OpTake: begin
        if (save_fill == 0) begin
          beat = '{data: '0, length: '0, last: 1'b0, empty: 1'b1};
          expected_beats.push_back(beat);
          empty_takes++;
        end else begin
          for (int k = 0; k < save_fill; k++) begin
            beat.data = save_mem[k];
            beat.length = uitf_pkg::LengthWidth'(save_fill);
            beat.last = (k + 1 == save_fill);
            beat.empty = 1'b0;
            expected_beats.push_back(beat);
          end
          save_fill = 0;
          frames_taken++;
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Compare every accepted result beat with the oldest expected one.
  always @(posedge clk) begin : check_results
    frame_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      beats_checked++;
      if (expected_beats.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with none expected, expected nothing, actual byte %0d len %0d",
                 $time, frame_byte, frame_length);
      end else begin
        want = expected_beats.pop_front();
        check_field("frame_byte", want.data, frame_byte);
        check_field("frame_length", want.length, frame_length);
        check_field("last_of_frame", want.last, last_of_frame);
        check_field("no_frame", want.empty, no_frame);
      end
    end
  end

  // Receiver side: random stall, or a long hold-off when one is requested.
  initial begin : receiver_stall
    int unsigned held;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        for (held = 0; held < HoldCycles; held++) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Offer one beat after a random gap and wait until the block takes it.
  task automatic send_item(input logic [uitf_pkg::OpWidth-1:0] op,
                           input logic [uitf_pkg::ByteWidth-1:0] value);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    byte_value <= value;
    do @(posedge clk); while (in_stall);
    apply_beat(op, value);
    if (op != OpUnused) items_sent++;
  endtask

  // Let every expected beat arrive and the block settle.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [uitf_pkg::TimeoutWidth-1:0] value);
    wait_for_drain();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    timeout_reg = value;
    timeout_writes++;
  endtask

  task automatic set_idling(input int unsigned tx_pct, input int unsigned rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
  endtask

  // Take with nothing saved, the unused operation and a tick while nothing is received.
  task automatic test_empty_take_and_unused();
    send_item(uitf_pkg::OpTake, 8'h00);
    send_item(OpUnused, 8'hFF);
    send_item(OpUnused, 8'h00);
    send_item(uitf_pkg::OpTick, 8'hFF);
    send_item(uitf_pkg::OpTake, 8'hFF);
  endtask

  // With the reset timeout, a short idle gap leaves the frame open.
  task automatic test_default_timeout();
    send_item(uitf_pkg::OpByte, 8'($urandom));
    repeat (ShortGap) send_item(uitf_pkg::OpTick, 8'($urandom));
    send_item(uitf_pkg::OpTake, 8'($urandom));
  endtask

  // Zero timeout: close on the first tick, then a pending frame that drops bytes.
  task automatic test_timeout_close_and_pending();
    write_timeout('0);
    send_item(uitf_pkg::OpByte, 8'h00);
    send_item(uitf_pkg::OpByte, 8'hFF);
    send_item(uitf_pkg::OpByte, 8'h5A);
    send_item(uitf_pkg::OpTick, 8'h00);
    send_item(uitf_pkg::OpByte, 8'h11);
    send_item(uitf_pkg::OpTick, 8'h00);
    send_item(uitf_pkg::OpByte, 8'h22);
    send_item(uitf_pkg::OpTick, 8'h00);
    send_item(uitf_pkg::OpTake, 8'h00);
    send_item(uitf_pkg::OpTick, 8'h00);
    send_item(uitf_pkg::OpTake, 8'h00);
    send_item(uitf_pkg::OpTake, 8'h00);
  endtask

  // Long receiver hold-off during a take, with more beats offered behind it.
  task automatic test_backpressure();
    write_timeout(16'd1);
    repeat (40) send_item(uitf_pkg::OpByte, 8'($urandom));
    repeat (2) send_item(uitf_pkg::OpTick, 8'($urandom));
    hold_pending = 1'b1;
    send_item(uitf_pkg::OpTake, 8'($urandom));
    repeat (6) send_item(uitf_pkg::OpByte, 8'($urandom));
    repeat (3) send_item(uitf_pkg::OpTick, 8'($urandom));
    send_item(uitf_pkg::OpTake, 8'($urandom));
  endtask

  // Byte bursts, idle gaps, takes and some noise, mostly as real traffic would look.
  task automatic run_random_traffic(input int unsigned count);
    int unsigned goal;
    int unsigned pick;
    int unsigned len;
    goal = items_sent + count;
    while (items_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        len = ($urandom_range(11) == 0) ? uitf_pkg::BufferDepth + $urandom_range(2) :
                                          $urandom_range(1, 8);
        repeat (len) begin
          send_item(uitf_pkg::OpByte, 8'($urandom));
          if ($urandom_range(5) == 0) send_item(uitf_pkg::OpTick, 8'($urandom));
        end
      end else if (pick < 78) begin
        len = (timeout_reg < 16) ? $urandom_range(1, timeout_reg + 3) : $urandom_range(1, 4);
        repeat (len) send_item(uitf_pkg::OpTick, 8'($urandom));
      end else if (pick < 96) begin
        send_item(uitf_pkg::OpTake, 8'($urandom));
      end else begin
        send_item(OpUnused, 8'($urandom));
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idling(29, 46);
    test_empty_take_and_unused();
    test_default_timeout();
    run_random_traffic(50);
    test_timeout_close_and_pending();
    run_random_traffic(45);

    set_idling(46, 29);
    write_timeout(16'd2);
    run_random_traffic(45);
    write_timeout(16'hFFFF);
    run_random_traffic(45);

    set_idling(0, 0);
    test_backpressure();
    run_random_traffic(40);
    write_timeout(16'd7);
    run_random_traffic(45);

    wait_for_drain();
    $display("Covered %0d input beats and %0d result beats: %0d frames, %0d empty takes.",
             items_sent, beats_checked, frames_taken, empty_takes);
    $display("Dropped %0d bytes on pending frames, %0d full-buffer closes, %0d timeout writes.",
             bytes_dropped, full_closes, timeout_writes);
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/uitf_pkg.sv
rtl/uitf_ram.sv
rtl/uart_rx_idle_timeout_framer.sv
tb/sv/uart_rx_idle_timeout_framer_test.sv
